/* design/ecf_pkg.sv */
// Shared types, constants and the month table for the epoch seconds to calendar converter.
// Used by ecf_ctrl, ecf_dpath, the top level, the checker and the testbench; depends on nothing.
package ecf_pkg;

  localparam logic [31:0] SecsPerDay     = 32'd86400;
  localparam logic [31:0] SecsPerHour    = 32'd3600;
  localparam logic [31:0] SecsPerMinute  = 32'd60;
  localparam logic [31:0] FirstUncovered = 32'd4102444800;

  localparam logic [15:0] DaysPerFourYears = 16'd1461;
  localparam logic [8:0]  DaysLeapYear     = 9'd366;
  localparam logic [8:0]  DaysCommonYear   = 9'd365;
  localparam logic [7:0]  BaseYear         = 8'd70;
  localparam logic [2:0]  WeekdayDayZero   = 3'd4;
  localparam logic [3:0]  DaysPerWeek      = 4'd7;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  // Reciprocals, rounded up, for the constant divisions:
  // 2^35/675 (days, after dropping 7 bits), 2^20/7 (weekday),
  // 2^21/225 (hours, after dropping 4 bits), 2^14/15 (minutes, after dropping 2 bits).
  localparam logic [25:0] DayRecip    = 26'd50903317;
  localparam logic [17:0] WeekRecip   = 18'd149797;
  localparam logic [13:0] HourRecip   = 14'd9321;
  localparam logic [10:0] MinuteRecip = 11'd1093;

  localparam int TdataWidth = 40;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY_DIV,
    S_DAY_REM,
    S_HOUR_DIV,
    S_HOUR_REM,
    S_MIN_DIV,
    S_MIN_REM,
    S_YEAR_INIT,
    S_YEAR,
    S_MONTH,
    S_FINISH,
    S_HOLD
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DAY_DIV,
    OP_DAY_REM,
    OP_HOUR_DIV,
    OP_HOUR_REM,
    OP_MIN_DIV,
    OP_MIN_REM,
    OP_YEAR_INIT,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic year_hit;
    logic month_hit;
  } dp_status_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [7:0] year_since_1900;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       out_of_range;
  } calendar_t;

  // Day of year on which each month starts, in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/ecf_ctrl.sv */
// Sequencing state machine of the converter: steps the datapath through the divisions,
// the year and month searches, and the hand-off to the output register. Uses ecf_pkg.
module ecf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                clock_ready,
  input  logic                out_free,
  input  ecf_pkg::dp_status_t status,
  output ecf_pkg::dp_op_t     cmd,
  output logic                in_ready,
  output logic                out_load
);
  import ecf_pkg::*;

  ctrl_state_t state, state_next;
  logic        accept;

  assign accept = in_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        // A word taken while the clock chip is not ready is dropped.
        if (accept && clock_ready) begin
          state_next = S_DAY_DIV;
        end
      end
      S_DAY_DIV:   state_next = S_DAY_REM;
      S_DAY_REM:   state_next = S_HOUR_DIV;
      S_HOUR_DIV:  state_next = S_HOUR_REM;
      S_HOUR_REM:  state_next = S_MIN_DIV;
      S_MIN_DIV:   state_next = S_MIN_REM;
      S_MIN_REM:   state_next = S_YEAR_INIT;
      S_YEAR_INIT: state_next = S_YEAR;
      S_YEAR: begin
        if (status.year_hit) begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        if (status.month_hit) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_HOLD;
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = OP_NONE;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd = OP_LOAD;
        end
      end
      S_DAY_DIV:   cmd = OP_DAY_DIV;
      S_DAY_REM:   cmd = OP_DAY_REM;
      S_HOUR_DIV:  cmd = OP_HOUR_DIV;
      S_HOUR_REM:  cmd = OP_HOUR_REM;
      S_MIN_DIV:   cmd = OP_MIN_DIV;
      S_MIN_REM:   cmd = OP_MIN_REM;
      S_YEAR_INIT: cmd = OP_YEAR_INIT;
      S_YEAR:      cmd = OP_YEAR_STEP;
      S_MONTH:     cmd = OP_MONTH_STEP;
      S_FINISH:    cmd = OP_FINISH;
      S_HOLD:      out_load = out_free;
      default:     cmd = OP_NONE;
    endcase
  end

endmodule

/* design/ecf_dpath.sv */
// Datapath of the converter: reciprocal multiplications for the constant divisors,
// the weekday residue, the year peeling and month search registers. Uses ecf_pkg.
module ecf_dpath (
  input  logic                clk,
  input  logic [31:0]         epoch_seconds,
  input  ecf_pkg::dp_op_t     cmd,
  output ecf_pkg::dp_status_t status,
  output ecf_pkg::calendar_t  result
);
  import ecf_pkg::*;

  logic [31:0] secs;
  logic [15:0] days;
  logic [16:0] tod;
  logic [14:0] wk_q;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [11:0] mrest;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [15:0] yrest;
  logic [7:0]  year;
  logic [3:0]  mon;
  logic [4:0]  day;
  logic        oor;

  logic [50:0] day_prod;
  logic [31:0] day_base;
  logic [31:0] tod_full;
  logic [16:0] wk_sum;
  logic [34:0] wk_prod;
  logic [16:0] wk_base;
  logic [16:0] wk_diff;
  logic [25:0] hour_prod;
  logic [16:0] hour_base;
  logic [16:0] tod_left;
  logic [19:0] min_prod;
  logic [11:0] min_base;
  logic [11:0] sec_full;
  logic        leap;
  logic        block_fits;
  logic [8:0]  year_days;
  logic [8:0]  mon_limit;
  logic [8:0]  day_full;

  // 86400 is 128 times 675, so the low seven bits are dropped before the multiply.
  assign day_prod = 51'(secs[31:7]) * 51'(DayRecip);
  assign day_base = 32'(days) * SecsPerDay;
  assign tod_full = secs - day_base;

  assign wk_sum  = {1'b0, days} + {14'd0, WeekdayDayZero};
  assign wk_prod = 35'(wk_sum) * 35'(WeekRecip);
  assign wk_base = 17'(wk_q) * 17'(DaysPerWeek);
  assign wk_diff = wk_sum - wk_base;

  assign hour_prod = 26'(tod[16:4]) * 26'(HourRecip);
  assign hour_base = 17'(hour) * SecsPerHour[16:0];
  assign tod_left  = tod - hour_base;

  assign min_prod = 20'(mrest[11:2]) * 20'(MinuteRecip);
  assign min_base = 12'(minute) * SecsPerMinute[11:0];
  assign sec_full = mrest - min_base;

  assign leap       = (year[1:0] == 2'b00);
  assign block_fits = leap && (yrest >= DaysPerFourYears);
  assign year_days  = leap ? DaysLeapYear : DaysCommonYear;
  assign mon_limit  = month_start(mon) + {8'd0, leap && (mon > MonthJan)};

  assign status.year_hit  = !block_fits && (yrest < {7'd0, year_days});
  assign status.month_hit = (mon == MonthDec) || (yrest < {7'd0, mon_limit});

  assign day_full = yrest[8:0] - month_start(mon - 4'd1) + 9'd1
                    - {8'd0, leap && (mon > MonthFeb)};

  always_ff @(posedge clk) begin
    case (cmd)
      OP_LOAD: begin
        secs <= epoch_seconds;
        oor  <= (epoch_seconds >= FirstUncovered);
      end
      OP_DAY_DIV: days <= day_prod[50:35];
      OP_DAY_REM: begin
        tod  <= tod_full[16:0];
        wk_q <= wk_prod[34:20];
      end
      OP_HOUR_DIV: begin
        hour    <= hour_prod[25:21];
        weekday <= wk_diff[2:0];
      end
      OP_HOUR_REM: mrest  <= tod_left[11:0];
      OP_MIN_DIV:  minute <= min_prod[19:14];
      OP_MIN_REM:  second <= sec_full[5:0];
      OP_YEAR_INIT: begin
        yrest <= days;
        year  <= BaseYear;
        mon   <= MonthJan;
      end
      OP_YEAR_STEP: begin
        // From a leap year on, four whole years are one block of fixed length.
        if (block_fits) begin
          yrest <= yrest - DaysPerFourYears;
          year  <= year + 8'd4;
        end else if (yrest >= {7'd0, year_days}) begin
          yrest <= yrest - {7'd0, year_days};
          year  <= year + 8'd1;
        end
      end
      OP_MONTH_STEP: begin
        if (!status.month_hit) begin
          mon <= mon + 4'd1;
        end
      end
      OP_FINISH: day <= day_full[4:0];
      default: ;
    endcase
  end

  assign result.weekday         = weekday;
  assign result.year_since_1900 = year;
  assign result.month           = mon;
  assign result.day_of_month    = day;
  assign result.hour            = hour;
  assign result.minute          = minute;
  assign result.second          = second;
  assign result.out_of_range    = oor;

endmodule

/* design/epoch_seconds_to_calendar_fields.sv */
// Channel   Dir  Word contents
// s_axis    in   tdata[31:0] epoch_seconds
// m_axis    out  tdata: date and time fields; tuser[0] out_of_range
// cfg       in   cfg_we / cfg_wdata[0] clock_ready
//
// One word at a time. After acceptance come the constant divisions, then the year steps
// (a four-year block from a leap year on, else one year), the month steps and the day of
// month; the result then waits for a free output register before it is loaded there.
// A word accepted while clock_ready is 0 gives no result. Reset is synchronous and clears
// the controller, the output valid and clock_ready. A finished result waits in the output
// register; the next word is accepted meanwhile, and the one after waits for it.
// Top level of the epoch seconds to calendar converter; uses ecf_pkg, ecf_ctrl, ecf_dpath.
module epoch_seconds_to_calendar_fields (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,     // clock_ready
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // [31:0] epoch_seconds
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] weekday, [10:3] year_since_1900, [14:11] month, [19:15] day_of_month,
  // [24:20] hour, [30:25] minute, [36:31] second, [39:37] zero
  output logic [ecf_pkg::TdataWidth-1:0]    m_axis_tdata,
  output logic                              m_axis_tuser   // [0] out_of_range
);
  import ecf_pkg::*;

  logic       clock_ready;
  logic       out_free;
  logic       out_load;
  dp_op_t     cmd;
  dp_status_t status;
  calendar_t  result;
  calendar_t  held;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ready <= 1'b0;
    end else if (cfg_we) begin
      clock_ready <= cfg_wdata;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  ecf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .clock_ready (clock_ready),
    .out_free    (out_free),
    .status      (status),
    .cmd         (cmd),
    .in_ready    (s_axis_tready),
    .out_load    (out_load)
  );

  ecf_dpath u_dpath (
    .clk           (clk),
    .epoch_seconds (s_axis_tdata),
    .cmd           (cmd),
    .status        (status),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {3'd0, held.second, held.minute, held.hour, held.day_of_month,
                         held.month, held.year_since_1900, held.weekday};
  assign m_axis_tuser = held.out_of_range;

endmodule

/* design/ecf_checker.sv */
// Port-level checker for the epoch seconds to calendar converter, bound to the top level.
// Depends on ecf_pkg for the output word width and the month and base year bounds.
module ecf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ecf_pkg::TdataWidth-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import ecf_pkg::*;

  logic [2:0] c_weekday;
  logic [7:0] c_year;
  logic [3:0] c_month;
  logic [4:0] c_day;
  logic [4:0] c_hour;
  logic [5:0] c_minute;
  logic [5:0] c_second;

  assign c_weekday = m_axis_tdata[2:0];
  assign c_year    = m_axis_tdata[10:3];
  assign c_month   = m_axis_tdata[14:11];
  assign c_day     = m_axis_tdata[19:15];
  assign c_hour    = m_axis_tdata[24:20];
  assign c_minute  = m_axis_tdata[30:25];
  assign c_second  = m_axis_tdata[36:31];

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> c_hour < 5'd24 && c_minute < 6'd60 && c_second < 6'd60
      && c_weekday < 3'd7)
    else $error("time of day field out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> c_month >= MonthJan && c_month <= MonthDec && c_day != 5'd0
      && c_year >= BaseYear && m_axis_tdata[39:37] == 3'd0)
    else $error("date field out of range");

  // The first uncovered second is the first day of year 200 exactly.
  a_range_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == (c_year >= 8'd200))
    else $error("out_of_range flag disagrees with year");

endmodule

bind epoch_seconds_to_calendar_fields ecf_checker u_ecf_checker (.*);

/* dv/epoch_seconds_to_calendar_fields_test.sv */
// Self-checking testbench for epoch_seconds_to_calendar_fields: directed and random words,
// each result checked against a calendar predictor kept in this file or a typed probe row.
// Depends on ecf_pkg (calendar_t, TdataWidth) and the converter RTL.
module epoch_seconds_to_calendar_fields_test;
  import ecf_pkg::*;

  localparam int unsigned SecondsPerDay = 86400;
  localparam int unsigned SecondsPerHour = 3600;
  localparam int unsigned SecondsPerMinute = 60;
  localparam logic [31:0] FirstUncoveredSecond = 32'd4102444800;
  localparam int unsigned MonthOffset [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                               304, 334};

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 200;
  localparam int LongHoldCycles = 600;
  localparam int RandomWords = 1550;
  localparam int MaxPrinted = 50;

  typedef struct {
    logic [31:0] secs;
    bit          typed;
    calendar_t   want;
  } probe_t;

  // Rows with typed=1 carry their expected result, under the every-fourth-year leap rule; the rest use the predictor.
  localparam int ProbeCount = 24;
  probe_t probes [ProbeCount] = '{
    '{32'd0,          1'b1, '{3'd4, 8'd70,  4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0}},
    '{32'd1,          1'b0, '0},
    '{32'd59,         1'b0, '0},
    '{32'd60,         1'b0, '0},
    '{32'd3599,       1'b0, '0},
    '{32'd3600,       1'b0, '0},
    '{32'd86399,      1'b0, '0},
    '{32'd86400,      1'b0, '0},
    '{32'd2678399,    1'b0, '0},
    '{32'd2678400,    1'b0, '0},
    '{32'd68169600,   1'b0, '0},
    '{32'd68256000,   1'b0, '0},
    '{32'd94694399,   1'b0, '0},
    '{32'd94694400,   1'b0, '0},
    '{32'd951782400,  1'b0, '0},
    '{32'd2147483647, 1'b0, '0},
    '{32'd2147483648, 1'b0, '0},
    '{32'd4102444799, 1'b1, '{3'd4, 8'd199, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0}},
    '{32'd4102444800, 1'b1, '{3'd5, 8'd200, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  1'b1}},
    '{32'd4107542400, 1'b0, '0},
    '{32'd4107628800, 1'b0, '0},
    '{32'hFFFF_FFFF,  1'b1, '{3'd0, 8'd206, 4'd2,  5'd6,  5'd6,  6'd28, 6'd15, 1'b1}},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;   // [31:0] epoch_seconds
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TdataWidth-1:0] m_axis_tdata;   // [2:0] weekday .. [36:31] second, [39:37] zero
  logic                  m_axis_tuser;   // [0] out_of_range

  epoch_seconds_to_calendar_fields DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  calendar_t pending_calendars [$];
  bit        clock_ready_shadow;
  int        mismatches;
  int        words_accepted;
  int        words_swallowed;
  int        results_checked;
  int        late_results;
  int        hold_requests;
  bit        sender_quiet;
  calendar_t seen_fields;
  calendar_t owed_fields;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Seconds to calendar fields, leap year every fourth year without exception.
  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    int unsigned total, days, tod, rest, yr, mon, dom;
    bit          leap;
    total = secs;
    days = total / SecondsPerDay;
    tod = total % SecondsPerDay;
    yr = 70;
    rest = days;
    while (rest >= ((yr % 4 == 0) ? 366 : 365)) begin
      rest -= (yr % 4 == 0) ? 366 : 365;
      yr++;
    end
    leap = (yr % 4 == 0);
    mon = 1;
    while (mon < 12 && rest >= MonthOffset[mon] + ((leap && mon > 1) ? 1 : 0))
      mon++;
    dom = rest - MonthOffset[mon - 1] + 1;
    if (leap && mon > 2)
      dom--;
    c.weekday = 3'((days + 4) % 7);
    c.year_since_1900 = 8'(yr);
    c.month = 4'(mon);
    c.day_of_month = 5'(dom);
    c.hour = 5'(tod / SecondsPerHour);
    c.minute = 6'((tod % SecondsPerHour) / SecondsPerMinute);
    c.second = 6'(tod % SecondsPerMinute);
    c.out_of_range = (secs >= FirstUncoveredSecond);
    return c;
  endfunction

  // Random seconds, weighted toward day, month, year and end-of-range boundaries.
  function automatic logic [31:0] pick_seconds();
    longint day_count, stamp;
    int     yr, mon;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: stamp = $urandom;
      4, 5:       stamp = $urandom_range(0, 32'd4102444799);
      6: begin
        day_count = $urandom_range(0, 49710);
        stamp = day_count * SecondsPerDay +
                ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(86396, 86399));
      end
      7: begin
        yr = $urandom_range(70, 206);
        day_count = 0;
        for (int k = 70; k < yr; k++)
          day_count += (k % 4 == 0) ? 366 : 365;
        mon = $urandom_range(0, 11);
        day_count += MonthOffset[mon] + ((yr % 4 == 0 && mon >= 2) ? 1 : 0);
        day_count += longint'($urandom_range(0, 2)) - 1;
        stamp = day_count * SecondsPerDay +
                ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(86396, 86399));
      end
      8:       stamp = longint'(FirstUncoveredSecond) + $urandom_range(0, 10000000) - 2000000;
      default: stamp = 64'hFFFF_FFFF - $urandom_range(0, 10000000);
    endcase
    return stamp[31:0];
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch at result %0d: %s expected %0d, got %0d",
               results_checked, what, want, got);
  endtask

  task automatic write_clock_ready(input logic value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    clock_ready_shadow = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one word and wait for the handshake; if the clock is ready, its expected result is queued.
  task automatic offer_seconds(input logic [31:0] secs, input bit typed, input calendar_t want);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= secs;
    do @(posedge clk); while (!s_axis_tready);
    words_accepted++;
    if (!clock_ready_shadow)
      words_swallowed++;
    else if (typed)
      pending_calendars.push_back(want);
    else
      pending_calendars.push_back(calendar_of(secs));
  endtask

  task automatic sender_gap();
    int gap;
    if (sender_quiet)
      gap = 0;
    else if ($urandom_range(0, 9) == 0)
      gap = $urandom_range(10, 50);
    else
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits for every owed result, then lets the design settle before the next write.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_calendars.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Result side: random stalls, a few long ones, quiet stretches, and the requested long hold.
  initial begin
    int stall_left, quiet_left, holds_done;
    stall_left = 0;
    quiet_left = 0;
    holds_done = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        stall_left = LongHoldCycles;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (quiet_left > 0)
          quiet_left--;
        else if ($urandom_range(0, 299) == 0)
          quiet_left = 400;
        else if ($urandom_range(0, 5) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
                                                     $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_fields.weekday = m_axis_tdata[2:0];
      seen_fields.year_since_1900 = m_axis_tdata[10:3];
      seen_fields.month = m_axis_tdata[14:11];
      seen_fields.day_of_month = m_axis_tdata[19:15];
      seen_fields.hour = m_axis_tdata[24:20];
      seen_fields.minute = m_axis_tdata[30:25];
      seen_fields.second = m_axis_tdata[36:31];
      seen_fields.out_of_range = m_axis_tuser;
      if (pending_calendars.size() == 0) begin
        report_mismatch("unexpected word, nothing owed; seconds field", -1, seen_fields.second);
      end else begin
        owed_fields = pending_calendars.pop_front();
        if (seen_fields.weekday != owed_fields.weekday)
          report_mismatch("weekday", owed_fields.weekday, seen_fields.weekday);
        if (seen_fields.year_since_1900 != owed_fields.year_since_1900)
          report_mismatch("year_since_1900", owed_fields.year_since_1900,
                          seen_fields.year_since_1900);
        if (seen_fields.month != owed_fields.month)
          report_mismatch("month", owed_fields.month, seen_fields.month);
        if (seen_fields.day_of_month != owed_fields.day_of_month)
          report_mismatch("day_of_month", owed_fields.day_of_month, seen_fields.day_of_month);
        if (seen_fields.hour != owed_fields.hour)
          report_mismatch("hour", owed_fields.hour, seen_fields.hour);
        if (seen_fields.minute != owed_fields.minute)
          report_mismatch("minute", owed_fields.minute, seen_fields.minute);
        if (seen_fields.second != owed_fields.second)
          report_mismatch("second", owed_fields.second, seen_fields.second);
        if (seen_fields.out_of_range != owed_fields.out_of_range)
          report_mismatch("out_of_range", owed_fields.out_of_range, seen_fields.out_of_range);
        if (m_axis_tdata[39:37] != 3'd0)
          report_mismatch("tdata padding", 0, m_axis_tdata[39:37]);
        if (seen_fields.out_of_range)
          late_results++;
      end
      results_checked++;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still owed", CycleLimit,
             pending_calendars.size());
    $display("** epoch_seconds_to_calendar_fields: FAILED **");
    $finish;
  end

  initial begin
    int burst_left;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    clock_ready_shadow = 1'b0;
    sender_quiet = 1'b0;
    hold_requests = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Straight out of reset the clock is not ready, so these words must vanish.
    for (int i = 0; i < 6; i++) begin
      offer_seconds(pick_seconds(), 1'b0, '0);
      sender_gap();
    end
    wait_idle();
    write_clock_ready(1'b1);

    for (int i = 0; i < ProbeCount; i++) begin
      offer_seconds(probes[i].secs, probes[i].typed, probes[i].want);
      sender_gap();
    end

    for (int i = 0; i < RandomWords; i++) begin
      if (i == 300) begin
        // Hold the result side off while words keep coming, so the input backs up.
        hold_requests++;
        burst_left = 40;
      end
      if (i == 750) begin
        wait_idle();
        write_clock_ready(1'b0);
        for (int k = 0; k < 30; k++) begin
          offer_seconds(pick_seconds(), 1'b0, '0);
          sender_gap();
        end
        wait_idle();
        write_clock_ready(1'b1);
      end
      if (burst_left == 0 && $urandom_range(0, 199) == 0)
        burst_left = $urandom_range(20, 60);
      sender_quiet = (burst_left > 0);
      if (burst_left > 0)
        burst_left--;
      offer_seconds(pick_seconds(), 1'b0, '0);
      sender_gap();
    end

    wait_idle();
    $display("%0d words accepted, %0d dropped while the clock was not ready", words_accepted,
             words_swallowed);
    $display("%0d results checked, %0d of them past the end of 2099, %0d mismatches",
             results_checked, late_results, mismatches);
    if (mismatches == 0) begin
      $display("** epoch_seconds_to_calendar_fields: PASSED **");
    end else begin
      $display("** epoch_seconds_to_calendar_fields: FAILED **");
    end
    $finish;
  end

endmodule

/* epoch_seconds_to_calendar_fields.f */
design/ecf_pkg.sv
design/ecf_ctrl.sv
design/ecf_dpath.sv
design/epoch_seconds_to_calendar_fields.sv
design/ecf_checker.sv
dv/epoch_seconds_to_calendar_fields_test.sv
